>>> design/pthc_pkg.sv
// Shared constants and types for the pressure, temperature and humidity compensation pipeline.
package pthc_pkg;

    localparam int DIV_STEPS = 64;
    localparam int NUM_WIDTH = 64;
    localparam int DEN_WIDTH = 31;
    localparam int CAL_REGS  = 4;

    localparam logic signed [32:0] T_FINE_P_OFFSET = 33'sd128000;
    localparam logic signed [31:0] T_FINE_H_OFFSET = 32'sd76800;
    localparam logic signed [31:0] HUM_MAX         = 32'sd419430400;
    localparam logic [20:0]        P_FULL_SCALE    = 21'd1048576;
    localparam logic [63:0]        P_DIV_SCALE     = 64'd3125;
    localparam logic signed [63:0] P_BIAS_47       = 64'sh0000_8000_0000_0000;
    localparam logic signed [31:0] HUM_ROUND_14    = 32'sd16384;
    localparam logic signed [31:0] HUM_OFFSET_21   = 32'sd2097152;
    localparam logic signed [31:0] HUM_ROUND_13    = 32'sd8192;
    localparam logic signed [31:0] HUM_OFFSET_15   = 32'sd32768;
    localparam logic signed [31:0] TEMP_ROUND      = 32'sd128;

    typedef enum logic [1:0] {
        CAL_REG_0_7   = 2'd0,
        CAL_REG_8_15  = 2'd1,
        CAL_REG_16_23 = 2'd2,
        CAL_REG_24_31 = 2'd3
    } t_cal_reg;

    typedef struct packed {
        logic [26:0] temp;
        logic [16:0] hum;
        logic        pvalid;
        logic        neg;
    } t_side;

endpackage

>>> design/pthc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband word.
module pthc_div
    import pthc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [NUM_WIDTH-1:0] i_num,
    input  logic [DEN_WIDTH-1:0] i_den,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [NUM_WIDTH-1:0] o_quo,
    output t_side                o_side
);

    logic [DIV_STEPS:0]   r_vld;
    logic [DEN_WIDTH-1:0] r_rem  [0:DIV_STEPS];
    logic [NUM_WIDTH-1:0] r_num  [0:DIV_STEPS];
    logic [DEN_WIDTH-1:0] r_den  [0:DIV_STEPS];
    t_side                r_side [0:DIV_STEPS];

    logic [DEN_WIDTH-1:0] n_rem  [0:DIV_STEPS-1];
    logic [NUM_WIDTH-1:0] n_num  [0:DIV_STEPS-1];
    logic [DEN_WIDTH+1:0] n_diff [0:DIV_STEPS-1];

    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_diff[k] = {1'b0, r_rem[k], r_num[k][NUM_WIDTH-1]} - {2'b00, r_den[k]};
            if (!n_diff[k][DEN_WIDTH+1]) begin
                n_rem[k] = n_diff[k][DEN_WIDTH-1:0];
            end else begin
                n_rem[k] = {r_rem[k][DEN_WIDTH-2:0], r_num[k][NUM_WIDTH-1]};
            end
            n_num[k] = {r_num[k][NUM_WIDTH-2:0], ~n_diff[k][DEN_WIDTH+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DIV_STEPS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_num[0]  <= i_num;
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        for (int k = 0; k < DIV_STEPS; k++) begin
            r_rem[k+1]  <= n_rem[k];
            r_num[k+1]  <= n_num[k];
            r_den[k+1]  <= r_den[k];
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_vld[DIV_STEPS];
    assign o_quo   = r_num[DIV_STEPS];
    assign o_side  = r_side[DIV_STEPS];

endmodule

>>> design/pth_sensor_compensation.sv
// Top level: pipelined fixed-point compensation of raw temperature, pressure and humidity.
// Throughput: one reading set per cycle; busy stays low, so start is taken in every cycle.
// Depth is set by the 64-stage pressure divider plus the multiplier stages around it.
// Reset (synchronous, i_rst_n low) clears all pipeline valid bits and the trim words to zero.
module pth_sensor_compensation
    import pthc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,
    input  logic [15:0] i_raw_humidity,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic signed [26:0] o_temperature_centi,
    output logic [31:0] o_pressure_q24_8,
    output logic        o_pressure_valid,
    output logic [16:0] o_humidity_q22_10
);

    // trim words
    logic [63:0] r_cal [0:CAL_REGS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CAL_REGS; k++) begin
                r_cal[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_cal[i_cfg_index] <= i_cfg_wdata;
        end
    end

    logic [15:0]        c_t1, c_p1;
    logic signed [15:0] c_t2, c_t3, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9, c_h2;
    logic [7:0]         c_h1, c_h3;
    logic signed [11:0] c_h4, c_h5;
    logic signed [7:0]  c_h6;

    assign c_t1 = r_cal[CAL_REG_0_7][15:0];
    assign c_t2 = r_cal[CAL_REG_0_7][31:16];
    assign c_t3 = r_cal[CAL_REG_0_7][47:32];
    assign c_p1 = r_cal[CAL_REG_0_7][63:48];
    assign c_p2 = r_cal[CAL_REG_8_15][15:0];
    assign c_p3 = r_cal[CAL_REG_8_15][31:16];
    assign c_p4 = r_cal[CAL_REG_8_15][47:32];
    assign c_p5 = r_cal[CAL_REG_8_15][63:48];
    assign c_p6 = r_cal[CAL_REG_16_23][15:0];
    assign c_p7 = r_cal[CAL_REG_16_23][31:16];
    assign c_p8 = r_cal[CAL_REG_16_23][47:32];
    assign c_p9 = r_cal[CAL_REG_16_23][63:48];
    assign c_h1 = r_cal[CAL_REG_24_31][7:0];
    assign c_h2 = r_cal[CAL_REG_24_31][23:8];
    assign c_h3 = r_cal[CAL_REG_24_31][31:24];
    assign c_h4 = {r_cal[CAL_REG_24_31][39:32], r_cal[CAL_REG_24_31][43:40]};
    assign c_h5 = {r_cal[CAL_REG_24_31][55:48], r_cal[CAL_REG_24_31][47:44]};
    assign c_h6 = r_cal[CAL_REG_24_31][63:56];

    assign busy = 1'b0;

    // front pipeline valid bits, stages 0..11
    logic [11:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[10:0], start & ~busy};
        end
    end

    // stage 0: capture
    logic [19:0] r0_rt, r0_rp;
    logic [15:0] r0_rh;

    always_ff @(posedge i_clk) begin
        r0_rt <= i_raw_temperature;
        r0_rp <= i_raw_pressure;
        r0_rh <= i_raw_humidity;
    end

    // stage 1: temperature products
    logic signed [17:0] n1_tx;
    logic signed [33:0] n1_tprod;
    logic signed [16:0] n1_td;
    logic signed [33:0] n1_tdsq;
    logic signed [31:0] r1_ta, r1_dsq;
    logic [19:0]        r1_rp;
    logic [15:0]        r1_rh;

    always_comb begin
        n1_tx    = $signed({1'b0, r0_rt[19:3]}) - $signed({1'b0, c_t1, 1'b0});
        n1_tprod = n1_tx * c_t2;
        n1_td    = $signed({1'b0, r0_rt[19:4]}) - $signed({1'b0, c_t1});
        n1_tdsq  = n1_td * n1_td;
    end

    always_ff @(posedge i_clk) begin
        r1_ta  <= n1_tprod[31:0];
        r1_dsq <= n1_tdsq[31:0];
        r1_rp  <= r0_rp;
        r1_rh  <= r0_rh;
    end

    // stage 2
    logic signed [31:0] n2_tb;
    logic signed [47:0] n2_tbp;
    logic signed [31:0] r2_a, r2_bp;
    logic [19:0]        r2_rp;
    logic [15:0]        r2_rh;

    always_comb begin
        n2_tb  = r1_dsq >>> 12;
        n2_tbp = n2_tb * c_t3;
    end

    always_ff @(posedge i_clk) begin
        r2_a  <= r1_ta >>> 11;
        r2_bp <= n2_tbp[31:0];
        r2_rp <= r1_rp;
        r2_rh <= r1_rh;
    end

    // stage 3: fine temperature
    logic signed [31:0] r3_tfine;
    logic [19:0]        r3_rp;
    logic [15:0]        r3_rh;

    always_ff @(posedge i_clk) begin
        r3_tfine <= r2_a + (r2_bp >>> 14);
        r3_rp    <= r2_rp;
        r3_rh    <= r2_rh;
    end

    // stage 4: temperature result, offsets
    logic signed [31:0] n4_tsum, n4_temp;
    logic [26:0]        r4_temp;
    logic signed [32:0] r4_v1;
    logic signed [31:0] r4_hv;
    logic [19:0]        r4_rp;
    logic [15:0]        r4_rh;

    always_comb begin
        n4_tsum = (r3_tfine <<< 2) + r3_tfine + TEMP_ROUND;
        n4_temp = n4_tsum >>> 8;
    end

    always_ff @(posedge i_clk) begin
        r4_temp <= n4_temp[26:0];
        r4_v1   <= $signed({r3_tfine[31], r3_tfine}) - T_FINE_P_OFFSET;
        r4_hv   <= r3_tfine - T_FINE_H_OFFSET;
        r4_rp   <= r3_rp;
        r4_rh   <= r3_rh;
    end

    // stage 5: first products
    logic signed [65:0] n5_sq;
    logic signed [48:0] n5_pm5, n5_pm2;
    logic signed [43:0] n5_h5v;
    logic signed [39:0] n5_b0p;
    logic signed [40:0] n5_b1p;
    logic [63:0]        r5_sq;
    logic signed [48:0] r5_pm5, r5_pm2;
    logic signed [31:0] r5_h5v, r5_b0p, r5_b1p;
    logic [26:0]        r5_temp;
    logic [19:0]        r5_rp;
    logic [15:0]        r5_rh;

    always_comb begin
        n5_sq  = r4_v1 * r4_v1;
        n5_pm5 = r4_v1 * c_p5;
        n5_pm2 = r4_v1 * c_p2;
        n5_h5v = c_h5 * r4_hv;
        n5_b0p = r4_hv * c_h6;
        n5_b1p = r4_hv * $signed({1'b0, c_h3});
    end

    always_ff @(posedge i_clk) begin
        r5_sq   <= n5_sq[63:0];
        r5_pm5  <= n5_pm5;
        r5_pm2  <= n5_pm2;
        r5_h5v  <= n5_h5v[31:0];
        r5_b0p  <= n5_b0p[31:0];
        r5_b1p  <= n5_b1p[31:0];
        r5_temp <= r4_temp;
        r5_rp   <= r4_rp;
        r5_rh   <= r4_rh;
    end

    // stage 6
    logic signed [79:0] n6_v2a, n6_v1a;
    logic signed [31:0] n6_hsum, n6_b0, n6_b1;
    logic signed [63:0] n6_b2p;
    logic signed [63:0] r6_v2a, r6_v1a;
    logic signed [48:0] r6_pm5, r6_pm2;
    logic signed [31:0] r6_ha, r6_b2p;
    logic [26:0]        r6_temp;
    logic [19:0]        r6_rp;

    always_comb begin
        n6_v2a  = $signed(r5_sq) * c_p6;
        n6_v1a  = $signed(r5_sq) * c_p3;
        n6_hsum = $signed({2'b00, r5_rh, 14'b0}) - $signed({c_h4, 20'b0}) - r5_h5v
                  + HUM_ROUND_14;
        n6_b0   = r5_b0p >>> 10;
        n6_b1   = (r5_b1p >>> 11) + HUM_OFFSET_15;
        n6_b2p  = n6_b0 * n6_b1;
    end

    always_ff @(posedge i_clk) begin
        r6_v2a  <= n6_v2a[63:0];
        r6_v1a  <= n6_v1a[63:0];
        r6_pm5  <= r5_pm5;
        r6_pm2  <= r5_pm2;
        r6_ha   <= n6_hsum >>> 15;
        r6_b2p  <= n6_b2p[31:0];
        r6_temp <= r5_temp;
        r6_rp   <= r5_rp;
    end

    // stage 7
    logic signed [63:0] n7_pm5, n7_pm2;
    logic signed [31:0] n7_b2;
    logic signed [47:0] n7_b3p;
    logic signed [63:0] r7_v2, r7_v1b;
    logic signed [31:0] r7_ha, r7_b3p;
    logic [26:0]        r7_temp;
    logic [19:0]        r7_rp;

    always_comb begin
        n7_pm5 = 64'(r6_pm5);
        n7_pm2 = 64'(r6_pm2);
        n7_b2  = (r6_b2p >>> 10) + HUM_OFFSET_21;
        n7_b3p = n7_b2 * c_h2;
    end

    always_ff @(posedge i_clk) begin
        r7_v2   <= r6_v2a + (n7_pm5 <<< 17) + $signed({{13{c_p4[15]}}, c_p4, 35'b0});
        r7_v1b  <= (r6_v1a >>> 8) + (n7_pm2 <<< 12);
        r7_ha   <= r6_ha;
        r7_b3p  <= n7_b3p[31:0];
        r7_temp <= r6_temp;
        r7_rp   <= r6_rp;
    end

    // stage 8
    logic signed [63:0] n8_vb;
    logic signed [80:0] n8_d1p;
    logic [20:0]        n8_p0;
    logic signed [31:0] n8_b3;
    logic signed [63:0] n8_hvp;
    logic signed [63:0] r8_d1p;
    logic [63:0]        r8_num0;
    logic signed [31:0] r8_hv;
    logic [26:0]        r8_temp;

    always_comb begin
        n8_vb  = r7_v1b + P_BIAS_47;
        n8_d1p = n8_vb * $signed({1'b0, c_p1});
        n8_p0  = P_FULL_SCALE - {1'b0, r7_rp};
        n8_b3  = (r7_b3p + HUM_ROUND_13) >>> 14;
        n8_hvp = r7_ha * n8_b3;
    end

    always_ff @(posedge i_clk) begin
        r8_d1p  <= n8_d1p[63:0];
        r8_num0 <= {11'b0, n8_p0, 32'b0} - {1'b0, {11'b0, n8_p0, 31'b0}} - r7_v2;
        r8_hv   <= n8_hvp[31:0];
        r8_temp <= r7_temp;
    end

    // stage 9
    logic signed [63:0] n9_den;
    logic signed [31:0] n9_hd;
    logic signed [63:0] n9_hdsq;
    logic signed [30:0] r9_den;
    logic [63:0]        r9_num;
    logic signed [31:0] r9_hv, r9_hdsq;
    logic [26:0]        r9_temp;

    always_comb begin
        n9_den  = r8_d1p >>> 33;
        n9_hd   = r8_hv >>> 15;
        n9_hdsq = n9_hd * n9_hd;
    end

    always_ff @(posedge i_clk) begin
        r9_den  <= n9_den[30:0];
        r9_num  <= r8_num0 * P_DIV_SCALE;
        r9_hv   <= r8_hv;
        r9_hdsq <= n9_hdsq[31:0];
        r9_temp <= r8_temp;
    end

    // stage 10: magnitudes and signs
    logic signed [31:0] n10_hs;
    logic signed [40:0] n10_hq;
    logic [63:0]        r10_nmag;
    logic [30:0]        r10_dmag;
    logic               r10_neg, r10_pvalid;
    logic signed [31:0] r10_hv, r10_hq;
    logic [26:0]        r10_temp;

    always_comb begin
        n10_hs = r9_hdsq >>> 7;
        n10_hq = n10_hs * $signed({1'b0, c_h1});
    end

    always_ff @(posedge i_clk) begin
        r10_nmag   <= r9_num[63] ? (64'd0 - r9_num) : r9_num;
        r10_dmag   <= r9_den[30] ? (31'd0 - r9_den) : r9_den;
        r10_neg    <= r9_num[63] ^ r9_den[30];
        r10_pvalid <= (r9_den != '0);
        r10_hv     <= r9_hv;
        r10_hq     <= n10_hq[31:0];
        r10_temp   <= r9_temp;
    end

    // stage 11: humidity clamp
    logic signed [31:0] n11_h;
    logic [31:0]        n11_hc;
    logic [63:0]        r11_nmag;
    logic [30:0]        r11_dmag;
    t_side              r11_side;

    always_comb begin
        n11_h = r10_hv - (r10_hq >>> 4);
        priority if (n11_h[31]) begin
            n11_hc = '0;
        end else if (n11_h > HUM_MAX) begin
            n11_hc = HUM_MAX;
        end else begin
            n11_hc = n11_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r11_nmag        <= r10_nmag;
        r11_dmag        <= r10_dmag;
        r11_side.temp   <= r10_temp;
        r11_side.hum    <= n11_hc[28:12];
        r11_side.pvalid <= r10_pvalid;
        r11_side.neg    <= r10_neg;
    end

    // divide
    logic        d_valid;
    logic [63:0] d_quo;
    t_side       d_side;

    pthc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[11]),
        .i_num   (r11_nmag),
        .i_den   (r11_dmag),
        .i_side  (r11_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    // back pipeline valid bits, stages q0..q3
    logic [3:0] r_qv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv     <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_qv     <= {r_qv[2:0], d_valid};
            o_strobe <= r_qv[3];
        end
    end

    // q0: restore sign
    logic signed [63:0] r_q0;
    t_side              r_q0_side;

    always_ff @(posedge i_clk) begin
        r_q0      <= d_side.neg ? (64'sd0 - $signed(d_quo)) : $signed(d_quo);
        r_q0_side <= d_side;
    end

    // q1
    logic signed [63:0] n_q1_ps;
    logic signed [79:0] n_q1_t9, n_q1_w2p;
    logic [63:0]        r_q1_t9, r_q1_ps;
    logic signed [63:0] r_q1_w2p, r_q1_q;
    t_side              r_q1_side;

    always_comb begin
        n_q1_ps  = r_q0 >>> 13;
        n_q1_t9  = n_q1_ps * c_p9;
        n_q1_w2p = r_q0 * c_p8;
    end

    always_ff @(posedge i_clk) begin
        r_q1_t9   <= n_q1_t9[63:0];
        r_q1_ps   <= n_q1_ps;
        r_q1_w2p  <= n_q1_w2p[63:0];
        r_q1_q    <= r_q0;
        r_q1_side <= r_q0_side;
    end

    // q2: partial products of the square term
    logic [63:0]        n_q2_lh, n_q2_hl;
    logic [63:0]        r_q2_ll;
    logic [31:0]        r_q2_lh, r_q2_hl;
    logic signed [63:0] r_q2_w2p, r_q2_q;
    t_side              r_q2_side;

    always_comb begin
        n_q2_lh = r_q1_t9[31:0] * r_q1_ps[63:32];
        n_q2_hl = r_q1_t9[63:32] * r_q1_ps[31:0];
    end

    always_ff @(posedge i_clk) begin
        r_q2_ll   <= r_q1_t9[31:0] * r_q1_ps[31:0];
        r_q2_lh   <= n_q2_lh[31:0];
        r_q2_hl   <= n_q2_hl[31:0];
        r_q2_w2p  <= r_q1_w2p;
        r_q2_q    <= r_q1_q;
        r_q2_side <= r_q1_side;
    end

    // q3
    logic [31:0]        n_q3_cross;
    logic signed [63:0] n_q3_prod;
    logic signed [63:0] r_q3_w1, r_q3_w2, r_q3_q;
    t_side              r_q3_side;

    always_comb begin
        n_q3_cross = r_q2_lh + r_q2_hl;
        n_q3_prod  = $signed(r_q2_ll + {n_q3_cross, 32'b0});
    end

    always_ff @(posedge i_clk) begin
        r_q3_w1   <= n_q3_prod >>> 25;
        r_q3_w2   <= r_q2_w2p >>> 19;
        r_q3_q    <= r_q2_q;
        r_q3_side <= r_q2_side;
    end

    // q4: final pressure, output word
    logic signed [63:0] n_q4_sum, n_q4_p;

    always_comb begin
        n_q4_sum = r_q3_q + r_q3_w1 + r_q3_w2;
        n_q4_p   = (n_q4_sum >>> 8) + $signed({{44{c_p7[15]}}, c_p7, 4'b0});
    end

    always_ff @(posedge i_clk) begin
        o_temperature_centi <= $signed(r_q3_side.temp);
        o_pressure_q24_8    <= r_q3_side.pvalid ? n_q4_p[31:0] : 32'd0;
        o_pressure_valid    <= r_q3_side.pvalid;
        o_humidity_q22_10   <= r_q3_side.hum;
    end

endmodule

>>> test/pth_sensor_compensation_tb.sv
// Self-checking testbench for the temperature, pressure and humidity compensation pipeline.
`timescale 1ns / 1ps

module pth_sensor_compensation_tb;
    import pthc_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RAND_PHASES  = 6;
    localparam int RAND_WORDS   = 75;

    typedef struct packed {
        logic signed [26:0] temp;
        logic [31:0]        pres;
        logic               pvalid;
        logic [16:0]        hum;
    } reading_t;

    typedef struct {
        logic [19:0] rt;
        logic [19:0] rp;
        logic [15:0] rh;
        bit          typed;
        reading_t    want;
        int          trim_set;
    } row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [19:0] i_raw_temperature;
    logic [19:0] i_raw_pressure;
    logic [15:0] i_raw_humidity;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_wdata;
    logic        o_strobe;
    logic signed [26:0] o_temperature_centi;
    logic [31:0] o_pressure_q24_8;
    logic        o_pressure_valid;
    logic [16:0] o_humidity_q22_10;

    logic [63:0] trim_words[CAL_REGS];
    logic [63:0] trim_sets[4][CAL_REGS];
    reading_t    pending_readings[$];
    row_t        rows[$];
    int          mismatches;
    int          words_sent;
    int          words_checked;
    int          invalid_seen;
    int          cycle_count;

    pth_sensor_compensation uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_raw_temperature(i_raw_temperature),
        .i_raw_pressure(i_raw_pressure),
        .i_raw_humidity(i_raw_humidity),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe(o_strobe),
        .o_temperature_centi(o_temperature_centi),
        .o_pressure_q24_8(o_pressure_q24_8),
        .o_pressure_valid(o_pressure_valid),
        .o_humidity_q22_10(o_humidity_q22_10)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic reading_t compensate(logic [19:0] raw_t, logic [19:0] raw_p,
                                            logic [15:0] raw_h);
        int     rt, rp, rh, t1, t2, t3, a, b, d, tfine, v, h1, h2, h3, h4, h5, h6;
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, w1, w2;
        reading_t r;
        rt = raw_t;
        rp = raw_p;
        rh = raw_h;
        t1 = trim_words[0][15:0];
        t2 = $signed(trim_words[0][31:16]);
        t3 = $signed(trim_words[0][47:32]);
        p1 = trim_words[0][63:48];
        p2 = $signed(trim_words[1][15:0]);
        p3 = $signed(trim_words[1][31:16]);
        p4 = $signed(trim_words[1][47:32]);
        p5 = $signed(trim_words[1][63:48]);
        p6 = $signed(trim_words[2][15:0]);
        p7 = $signed(trim_words[2][31:16]);
        p8 = $signed(trim_words[2][47:32]);
        p9 = $signed(trim_words[2][63:48]);
        h1 = trim_words[3][7:0];
        h2 = $signed(trim_words[3][23:8]);
        h3 = trim_words[3][31:24];
        h4 = (int'($signed(trim_words[3][39:32])) <<< 4) | int'(trim_words[3][43:40]);
        h5 = (int'($signed(trim_words[3][55:48])) <<< 4) | int'(trim_words[3][47:44]);
        h6 = $signed(trim_words[3][63:56]);

        a = (((rt >>> 3) - (t1 <<< 1)) * t2) >>> 11;
        d = (rt >>> 4) - t1;
        b = (((d * d) >>> 12) * t3) >>> 14;
        tfine = a + b;
        r.temp = 27'((tfine * 5 + 128) >>> 8);

        v1 = longint'(tfine) - 64'sd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = ((P_BIAS_47 + v1) * p1) >>> 33;
        r.pres = '0;
        r.pvalid = 1'b0;
        if (v1 != 0) begin
            r.pvalid = 1'b1;
            p = 64'sd1048576 - longint'(rp);
            p = ((p <<< 31) - v2) * 64'sd3125;
            if (v1 == -64'sd1)
                p = -p;
            else
                p = p / v1;
            w1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            w2 = (p8 * p) >>> 19;
            p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
            r.pres = p[31:0];
        end

        v = tfine - 76800;
        a = ((rh <<< 14) - (h4 <<< 20) - h5 * v + 16384) >>> 15;
        b = ((((v * h6) >>> 10) * (((v * h3) >>> 11) + 32768)) * 1) >>> 10;
        b = ((b + 2097152) * h2 + 8192) >>> 14;
        v = a * b;
        d = v >>> 15;
        v = v - ((((d * d) >>> 7) * h1) >>> 4);
        if (v < 0)
            v = 0;
        if (v > HUM_MAX)
            v = HUM_MAX;
        r.hum = 17'(v >>> 12);
        return r;
    endfunction

    always @(posedge i_clk) begin
        reading_t exp_r;
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n && o_strobe) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word temp=%0d pres=%h valid=%b hum=%0d", $time,
                         o_temperature_centi, o_pressure_q24_8, o_pressure_valid,
                         o_humidity_q22_10);
            end else begin
                exp_r = pending_readings.pop_front();
                words_checked++;
                if (!exp_r.pvalid)
                    invalid_seen++;
                if (o_temperature_centi !== exp_r.temp) begin
                    mismatches++;
                    $display("%0t: temperature expected %0d actual %0d", $time,
                             exp_r.temp, o_temperature_centi);
                end
                if (o_pressure_q24_8 !== exp_r.pres) begin
                    mismatches++;
                    $display("%0t: pressure expected %h actual %h", $time,
                             exp_r.pres, o_pressure_q24_8);
                end
                if (o_pressure_valid !== exp_r.pvalid) begin
                    mismatches++;
                    $display("%0t: pressure valid expected %b actual %b", $time,
                             exp_r.pvalid, o_pressure_valid);
                end
                if (o_humidity_q22_10 !== exp_r.hum) begin
                    mismatches++;
                    $display("%0t: humidity expected %0d actual %0d", $time,
                             exp_r.hum, o_humidity_q22_10);
                end
            end
        end
        if (i_rst_n && i_cfg_we)
            trim_words[i_cfg_index] = i_cfg_wdata;
        if (i_rst_n && start && !busy) begin
            pending_readings.push_back(compensate(i_raw_temperature, i_raw_pressure,
                                                  i_raw_humidity));
            words_sent++;
        end
    end

    task automatic drain();
        while (pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_trim(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                             logic [63:0] w3);
        logic [63:0] w[CAL_REGS];
        w = '{w0, w1, w2, w3};
        start <= 1'b0;
        drain();
        for (int k = 0; k < CAL_REGS; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_cal_reg'(k);
            i_cfg_wdata <= w[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_word(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh,
                             int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start             <= 1'b1;
        i_raw_temperature <= rt;
        i_raw_pressure    <= rp;
        i_raw_humidity    <= rh;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic add_row(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh, int set,
                           bit typed);
        row_t r;
        r.rt = rt;
        r.rp = rp;
        r.rh = rh;
        r.typed = typed;
        r.want = '0;
        r.trim_set = set;
        rows.push_back(r);
    endtask

    initial begin
        int       cur_set;
        int       idle_pct;
        int       pct_list[4];
        reading_t got;
        pct_list = '{0, 73, 0, 37};
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        invalid_seen = 0;
        cycle_count = 0;
        for (int k = 0; k < CAL_REGS; k++)
            trim_words[k] = '0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_raw_temperature = '0;
        i_raw_pressure = '0;
        i_raw_humidity = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CAL_REG_0_7;
        i_cfg_wdata = '0;

        trim_sets[0] = '{64'h0, 64'h0, 64'h0, 64'h0};
        trim_sets[1] = '{64'h8E7D_FC18_6743_6B70, 64'h008C_0B27_0BD0_D643,
                         64'h1770_C6F8_3C8C_FFF9, 64'h1E03_2913_0001_6A4B};
        // divisor of minus one: tfine = -920592, P1 = 1, P2 = 0, P3 = -32768
        trim_sets[2] = '{64'h0001_0000_8000_0000, 64'h1234_0567_8000_0000,
                         64'h0ABC_F123_2345_FFF0, 64'h1E03_2913_0001_6A4B};
        trim_sets[3] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                         64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};

        add_row(20'h00000, 20'h00000, 16'h0000, 0, 1);
        add_row(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0, 1);
        add_row(20'hAAAAA, 20'h55555, 16'hA5A5, 0, 1);
        add_row(20'h55555, 20'hAAAAA, 16'h5A5A, 0, 1);
        add_row(20'd519888, 20'd415148, 16'd30000, 1, 0);
        add_row(20'd519888, 20'd415148, 16'hFFFF, 1, 0);
        add_row(20'd519888, 20'd415148, 16'h0000, 1, 0);
        add_row(20'h00000, 20'h00000, 16'h0000, 1, 0);
        add_row(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1, 0);
        add_row(20'h80000, 20'h80000, 16'h8000, 1, 0);
        add_row(20'd460296, 20'd415148, 16'd30000, 2, 0);
        add_row(20'd460296, 20'h00000, 16'h0000, 2, 0);
        add_row(20'd460296, 20'hFFFFF, 16'hFFFF, 2, 0);
        add_row(20'h00000, 20'h00000, 16'h0000, 3, 0);
        add_row(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 3, 0);
        add_row(20'h12345, 20'h6789A, 16'hBCDE, 3, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_set = 0;
        foreach (rows[n]) begin
            if (rows[n].trim_set != cur_set) begin
                cur_set = rows[n].trim_set;
                load_trim(trim_sets[cur_set][0], trim_sets[cur_set][1],
                          trim_sets[cur_set][2], trim_sets[cur_set][3]);
            end
            if (rows[n].typed) begin
                got = compensate(rows[n].rt, rows[n].rp, rows[n].rh);
                if (got !== rows[n].want) begin
                    mismatches++;
                    $display("%0t: zero-trim row %0d expected %h actual %h", $time, n,
                             rows[n].want, got);
                end
            end
            send_word(rows[n].rt, rows[n].rp, rows[n].rh, 0);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: load_trim(trim_sets[1][0], trim_sets[1][1], trim_sets[1][2],
                             trim_sets[1][3]);
                1: load_trim({$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom});
                2: load_trim(trim_sets[3][0], trim_sets[3][1], trim_sets[3][2],
                             trim_sets[3][3]);
                3: load_trim(trim_sets[1][0] ^ 64'($urandom_range(255)),
                             trim_sets[1][1] ^ {48'h0, 16'($urandom)},
                             trim_sets[1][2] ^ {16'($urandom), 48'h0},
                             {$urandom, $urandom});
                4: load_trim(64'h0, {$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom});
                default: load_trim({$urandom, $urandom}, {$urandom, $urandom},
                                   {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            idle_pct = pct_list[ph % 4];
            for (int n = 0; n < RAND_WORDS; n++) begin
                if (n == RAND_WORDS / 2) begin
                    start <= 1'b0;
                    drain();
                end
                if ($urandom_range(9) < 7)
                    send_word(20'd400000 + 20'($urandom_range(200000)),
                              20'd300000 + 20'($urandom_range(200000)),
                              16'($urandom), idle_pct);
                else
                    send_word(20'($urandom), 20'($urandom), 16'($urandom), idle_pct);
            end
        end

        start <= 1'b0;
        drain();
        $display("sent %0d words over zero, typical, extreme, divisor -1 and random trims",
                 words_sent);
        $display("checked %0d results, %0d with invalid pressure", words_checked,
                 invalid_seen);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
